[hw/rtl/rme_pkg.sv]
// Shared types and codes for the RSA modular exponentiation block.
`timescale 1ns / 1ps
`default_nettype none
package rme_pkg;

  // Request codes
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_PUB_EXP  = 2'd0;
  localparam logic [1:0] REG_PRIV_EXP = 2'd1;
  localparam logic [1:0] REG_MODULUS  = 2'd2;

  // Control for the multiplier bit chain
  typedef struct packed {
    logic load;
    logic shift;
  } chain_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/rme_cell.sv]
// One cell of the multiplier bit chain: holds one bit, passes it up each step.
`timescale 1ns / 1ps
`default_nettype none
module rme_cell (
  input  wire logic              clk,
  input  wire rme_pkg::chain_ctl_t ctl,
  input  wire logic              load_bit,
  input  wire logic              prev_bit,
  output logic                   bit_q
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      bit_q <= load_bit;
    end else if (ctl.shift) begin
      bit_q <= prev_bit;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/rme_modstep.sv]
// One interleaved shift-add-reduce step: (2*acc + bit*x) mod m.
`timescale 1ns / 1ps
`default_nettype none
module rme_modstep #(
  parameter int WORD_WIDTH = 64
) (
  input  wire logic [WORD_WIDTH-1:0] acc,
  input  wire logic [WORD_WIDTH-1:0] x,
  input  wire logic [WORD_WIDTH-1:0] m,
  input  wire logic                  y_bit,
  output logic      [WORD_WIDTH-1:0] acc_next
);

  logic [WORD_WIDTH:0]   dbl;
  logic [WORD_WIDTH-1:0] red1;
  logic [WORD_WIDTH:0]   sum;
  logic [WORD_WIDTH:0]   m_ext;

  // acc, x < m, so each partial sum stays below 2m: one subtract suffices
  always_comb begin
    m_ext = {1'b0, m};
    dbl   = {acc, 1'b0};
    red1  = (dbl >= m_ext) ? WORD_WIDTH'(dbl - m_ext) : dbl[WORD_WIDTH-1:0];
    sum   = {1'b0, red1} + (y_bit ? {1'b0, x} : '0);
    acc_next = (sum >= m_ext) ? WORD_WIDTH'(sum - m_ext) : sum[WORD_WIDTH-1:0];
  end

endmodule
`default_nettype wire

[hw/rtl/rsa_modular_exponentiation.sv]
// Top level of the RSA modular exponentiation block.
// Computes base^exponent mod modulus by right-to-left square-and-multiply.
// Encrypt (cmd 0) raises the low byte of value to the public exponent;
// decrypt (cmd 1) raises the whole word to the private exponent and returns
// the low byte zero-extended. A zero base or a zero modulus gives 0. One item
// is in flight at a time: in_ready is high only while idle, and the next
// request is taken after the result transfer. Each modular multiplication
// runs in a single shift-add-reduce unit, fed one multiplier bit per cycle
// from the top of a chain of WORD_WIDTH bit cells. The base is first reduced
// mod the modulus by one such multiplication. Configuration writes are
// always taken (cfg_ready is tied high) and must only occur while idle.
`timescale 1ns / 1ps
`default_nettype none
module rsa_modular_exponentiation #(
  parameter int WORD_WIDTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  cmd,
  input  wire logic [WORD_WIDTH-1:0] value,
  // result
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [WORD_WIDTH-1:0] result,
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [WORD_WIDTH-1:0] cfg_data
);

  localparam int CW = $clog2(WORD_WIDTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_EXP  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;

  // which multiplication is running
  localparam logic [1:0] K_RED = 2'd0;  // base mod m
  localparam logic [1:0] K_AM  = 2'd1;  // acc * sq
  localparam logic [1:0] K_SQ  = 2'd2;  // sq * sq

  logic [WORD_WIDTH-1:0] pub_exp;
  logic [WORD_WIDTH-1:0] dec_exp;
  logic [WORD_WIDTH-1:0] modulus;

  logic [2:0]            state;
  logic [1:0]            kind;
  logic [CW-1:0]         cnt;
  logic                  dec;
  logic [WORD_WIDTH-1:0] m_r;
  logic [WORD_WIDTH-1:0] e_r;
  logic [WORD_WIDTH-1:0] racc;   // running result
  logic [WORD_WIDTH-1:0] sq;     // running square
  logic [WORD_WIDTH-1:0] macc;   // multiplier accumulator
  logic [WORD_WIDTH-1:0] mx;     // multiplicand

  logic [WORD_WIDTH-1:0] base;
  logic [WORD_WIDTH-1:0] y_load;
  logic [WORD_WIDTH-1:0] chain;
  logic [WORD_WIDTH-1:0] macc_next;
  rme_pkg::chain_ctl_t   cctl;
  logic                  in_xfer;
  logic                  last;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign last      = (cnt == CW'(WORD_WIDTH - 1));

  assign base = (cmd == rme_pkg::CMD_ENCRYPT) ?
                {{(WORD_WIDTH-8){1'b0}}, value[7:0]} : value;

  // Chain loads at the start of each multiplication, shifts while it runs
  always_comb begin
    cctl.load  = 1'b0;
    cctl.shift = (state == S_MUL);
    y_load     = sq;
    if (in_xfer) begin
      cctl.load = 1'b1;
      y_load    = base;
    end else if (state == S_EXP) begin
      cctl.load = 1'b1;
      y_load    = sq;
    end else if (state == S_MUL && last && kind == K_AM) begin
      cctl.load  = 1'b1;
      cctl.shift = 1'b0;
      y_load     = sq;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < WORD_WIDTH; gi++) begin : g_cell
      rme_cell u_cell (
        .clk      (clk),
        .ctl      (cctl),
        .load_bit (y_load[gi]),
        .prev_bit ((gi == 0) ? 1'b0 : chain[(gi == 0) ? 0 : gi-1]),
        .bit_q    (chain[gi])
      );
    end
  endgenerate

  rme_modstep #(.WORD_WIDTH(WORD_WIDTH)) u_step (
    .acc      (macc),
    .x        (mx),
    .m        (m_r),
    .y_bit    (chain[WORD_WIDTH-1]),
    .acc_next (macc_next)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pub_exp  <= WORD_WIDTH'(65537);
      dec_exp  <= WORD_WIDTH'(1);
      modulus  <= WORD_WIDTH'(3233);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rme_pkg::REG_PUB_EXP:  pub_exp  <= cfg_data;
        rme_pkg::REG_PRIV_EXP: dec_exp  <= cfg_data;
        rme_pkg::REG_MODULUS:  modulus  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= K_RED;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            dec  <= (cmd == rme_pkg::CMD_DECRYPT);
            m_r  <= modulus;
            e_r  <= (cmd == rme_pkg::CMD_ENCRYPT) ? pub_exp : dec_exp;
            macc <= '0;
            mx   <= WORD_WIDTH'(1);
            kind <= K_RED;
            cnt  <= '0;
            if (modulus == '0 || base == '0) begin
              result <= '0;
              state  <= S_OUT;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (last) begin
            cnt  <= '0;
            macc <= '0;
            case (kind)
              K_RED: begin
                // modulus one: base reduces to 0 and 1 mod m is 0
                sq    <= macc_next;
                racc  <= {{(WORD_WIDTH-1){1'b0}}, (m_r != WORD_WIDTH'(1))};
                state <= S_EXP;
              end
              K_AM: begin
                racc <= macc_next;
                mx   <= sq;
                kind <= K_SQ;
              end
              default: begin
                sq    <= macc_next;
                e_r   <= e_r >> 1;
                state <= S_EXP;
              end
            endcase
          end else begin
            macc <= macc_next;
            cnt  <= cnt + 1'b1;
          end
        end
        S_EXP: begin
          if (e_r == '0) begin
            result <= dec ? {{(WORD_WIDTH-8){1'b0}}, racc[7:0]} : racc;
            state  <= S_OUT;
          end else begin
            kind  <= e_r[0] ? K_AM : K_SQ;
            mx    <= e_r[0] ? racc : sq;
            macc  <= '0;
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_out_lt_mod: assert property (@(posedge clk) disable iff (rst)
    out_valid && m_r != '0 |-> result < m_r)
    else $error("result not reduced");

  a_dec_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && dec |-> result[WORD_WIDTH-1:8] == '0)
    else $error("decrypt result wider than a byte");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the RSA modular exponentiation block.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int W = 64;
  localparam int WATCHDOG_LIMIT = 200000;

  // Expected results of accepted requests, oldest first, and the mismatch tally.
  class modexp_scoreboard;
    logic [W-1:0] pending_results[$];
    int errors = 0;

    function void note_request(logic [W-1:0] expected);
      pending_results.push_back(expected);
    endfunction

    function void check_result(logic [W-1:0] got);
      logic [W-1:0] want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want !== got) begin
          $display("%0t: result mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic cmd = rme_pkg::CMD_ENCRYPT;
  logic [W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [W-1:0] result;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = rme_pkg::REG_PUB_EXP;
  logic [W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  rsa_modular_exponentiation #(.WORD_WIDTH(W)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  modexp_scoreboard sb = new();

  // Local copy of the configuration registers.
  logic [W-1:0] pub_exp_q, dec_exp_q, mod_q;

  // (a + b) mod m for a, b < m, no overflow.
  function automatic logic [W-1:0] add_mod(logic [W-1:0] a, logic [W-1:0] b,
                                           logic [W-1:0] m);
    logic [W-1:0] room;
    room = m - b;
    return (a >= room) ? a - room : a + b;
  endfunction

  function automatic logic [W-1:0] mul_mod(logic [W-1:0] a, logic [W-1:0] b,
                                           logic [W-1:0] m);
    logic [W-1:0] acc;
    acc = '0;
    for (int i = W - 1; i >= 0; i--) begin
      acc = add_mod(acc, acc, m);
      if (b[i]) acc = add_mod(acc, a, m);
    end
    return acc;
  endfunction

  function automatic logic [W-1:0] pow_mod(logic [W-1:0] b, logic [W-1:0] e,
                                           logic [W-1:0] m);
    logic [W-1:0] acc, sq;
    if (m == 0 || b == 0) return '0;
    acc = (m == 1) ? '0 : 1;
    sq = b % m;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, sq, m);
      e = e >> 1;
      sq = mul_mod(sq, sq, m);
    end
    return acc;
  endfunction

  function automatic logic [W-1:0] rsa_expected(logic c, logic [W-1:0] v);
    logic [W-1:0] r;
    if (c == rme_pkg::CMD_ENCRYPT) return pow_mod({56'd0, v[7:0]}, pub_exp_q, mod_q);
    r = pow_mod(v, dec_exp_q, mod_q);
    return {56'd0, r[7:0]};
  endfunction

  // Bookkeeping at the rising edge; all transfers are seen here.
  int idle_cycles = 0;
  int results_seen = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(rsa_expected(cmd, value));
      if (out_valid && out_ready) begin
        sb.check_result(result);
        results_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rme_pkg::REG_PUB_EXP:  pub_exp_q <= cfg_data;
          rme_pkg::REG_PRIV_EXP: dec_exp_q <= cfg_data;
          rme_pkg::REG_MODULUS:  mod_q <= cfg_data;
          default: ;
        endcase
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: random stall pattern, one long hold-off, and some full-rate stretches.
  bit hold_off = 0;
  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 0;
    else if ((results_seen / 16) % 3 == 0) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic write_reg(logic [1:0] idx, logic [W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Present one request and hold it until the transfer.
  task automatic send_request(logic c, logic [W-1:0] v);
    cmd <= c;
    value <= v;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Burst of n requests, then a random gap with valid low.
  task automatic send_burst(int n);
    for (int i = 0; i < n; i++) send_request(rand_cmd(), rand_value());
    in_valid <= 0;
    repeat ($urandom_range(0, 6)) @(negedge clk);
  endtask

  function automatic logic rand_cmd();
    return $urandom_range(0, 1);
  endfunction

  function automatic logic [W-1:0] rand_value();
    logic [W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: v = v & 64'hFF;
      1: v = v & 64'hFFFF;
      default: ;
    endcase
    return v;
  endfunction

  // Exponents kept short mostly, so most items stay quick.
  function automatic logic [W-1:0] rand_exp();
    logic [W-1:0] e;
    e = {$urandom, $urandom};
    if ($urandom_range(0, 7) != 0) e = e & 64'hFFFF;
    return e;
  endfunction

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_config(logic [W-1:0] pe, logic [W-1:0] de, logic [W-1:0] m);
    write_reg(rme_pkg::REG_PUB_EXP, pe);
    write_reg(rme_pkg::REG_PRIV_EXP, de);
    write_reg(rme_pkg::REG_MODULUS, m);
  endtask

  initial begin
    pub_exp_q = 65537;
    dec_exp_q = 1;
    mod_q = 3233;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: reset settings, zero base, extremes of value, both commands.
    send_request(rme_pkg::CMD_ENCRYPT, 64'd65);
    send_request(rme_pkg::CMD_DECRYPT, 64'd2790);
    send_request(rme_pkg::CMD_ENCRYPT, 64'd0);
    send_request(rme_pkg::CMD_DECRYPT, 64'd0);
    send_request(rme_pkg::CMD_ENCRYPT, '1);
    send_request(rme_pkg::CMD_DECRYPT, '1);
    send_request(rme_pkg::CMD_ENCRYPT, 64'hFFFF_FFFF_FFFF_FF00);
    drain();

    // Zero exponents: nonzero base gives 1, zero base still 0.
    set_config(64'd0, 64'd0, 64'd97);
    send_request(rme_pkg::CMD_ENCRYPT, 64'd5);
    send_request(rme_pkg::CMD_DECRYPT, 64'd0);
    send_request(rme_pkg::CMD_DECRYPT, 64'd12345);
    drain();

    // Modulus one, and the out-of-range modulus zero.
    set_config(64'd3, 64'd7, 64'd1);
    send_request(rme_pkg::CMD_ENCRYPT, 64'd9);
    send_request(rme_pkg::CMD_DECRYPT, 64'd9);
    drain();
    write_reg(rme_pkg::REG_MODULUS, 64'd0);
    send_request(rme_pkg::CMD_ENCRYPT, 64'd9);
    send_request(rme_pkg::CMD_DECRYPT, 64'd9);
    drain();

    // Full-width extremes: top modulus and all-ones exponents.
    set_config('1, '1, '1);
    send_request(rme_pkg::CMD_ENCRYPT, 64'd255);
    send_request(rme_pkg::CMD_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFE);
    drain();
    write_reg(rme_pkg::REG_MODULUS, 64'd2);
    send_request(rme_pkg::CMD_ENCRYPT, 64'd3);
    send_request(rme_pkg::CMD_DECRYPT, 64'd4);
    drain();

    // Short exponents so results come back well inside the hold-off.
    set_config(64'd3, 64'd5, 64'd3233);

    // Index three is not a register; the write must change nothing.
    write_reg(2'd3, 64'd12345);
    write_reg(rme_pkg::REG_MODULUS, 64'hFFFF_FFFF_FFFF_FFC5);

    // Long receiver hold-off while requests keep coming.
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      send_burst(4);
    join
    drain();

    // Random phases with fresh settings.
    for (int ph = 0; ph < 5; ph++) begin
      set_config(rand_exp(), rand_exp(),
                 (ph % 2) ? ({$urandom, $urandom} | 64'h2) : $urandom_range(2, 70000));
      for (int n = 0; n < 22;) begin
        int k;
        k = $urandom_range(1, 5);
        send_burst(k);
        n += k;
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
